// ----- hdl/deq_pkg.sv -----
// Shared types and codes for the double-ended queue.
// Used by deq_ctrl, deq_dp and the double_ended_queue top level.
`default_nettype none

package deq_pkg;

  // Default sizes
  localparam int unsigned DefDepth     = 8;
  localparam int unsigned DefDataWidth = 32;

  // Fixed port widths
  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned StatusWidth = 2;

  // Command codes
  localparam logic [CmdWidth-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CmdWidth-1:0] CMD_POP_REAR   = 2'd3;

  // Status codes
  localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
  localparam logic [StatusWidth-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatusWidth-1:0] ST_UNDERFLOW = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;      // execute the accepted item this cycle
    logic load_mem;  // move read data into the output word register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pop_ok;    // current item is a pop that will remove a word
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/deq_ctrl.sv -----
// Controller of the double-ended queue: handshake and result sequencing.
// Depends on deq_pkg for the command and status structs.
`default_nettype none

module deq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire deq_pkg::dp_sts_t  sts_i,
  output deq_pkg::ctl_cmd_t      cmd_o
);
  import deq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec;

  // Take an item only when the output register is free or drains now
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign exec       = in_valid_i && in_ready_o;

  assign cmd_o.exec     = exec;
  assign cmd_o.load_mem = (state_q == S_READ);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (exec && sts_i.pop_ok) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: drop on take, raise when a result is complete
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (state_q == S_READ) begin
      out_valid_d = 1'b1;
    end
    if (exec && !sts_i.pop_ok) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/deq_dp.sv -----
// Datapath of the double-ended queue: store, end pointers, fill count
// and result registers. Depends on deq_pkg for codes and structs.
`default_nettype none

module deq_dp #(
  parameter int unsigned Depth     = deq_pkg::DefDepth,
  parameter int unsigned DataWidth = deq_pkg::DefDataWidth,
  localparam int unsigned IdxW     = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW     = $clog2(Depth + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire deq_pkg::ctl_cmd_t                   cmd_i,
  output deq_pkg::dp_sts_t                         sts_o,
  input  wire logic [deq_pkg::CmdWidth-1:0]        command_i,
  input  wire logic signed [deq_pkg::WordWidth-1:0] data_in_i,
  output logic signed [deq_pkg::WordWidth-1:0]     data_out_o,
  output logic [deq_pkg::StatusWidth-1:0]          status_o,
  output logic [CntW-1:0]                          level_o
);
  import deq_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  function automatic logic [IdxW-1:0] step_up(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] step_dn(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rd_q;

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, slot;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            is_push, is_front, full, empty, push_ok, pop_ok;
  logic [StatusWidth-1:0] status_d;
  logic [DataWidth-1:0]   word;

  assign is_push  = (command_i == CMD_PUSH_FRONT) || (command_i == CMD_PUSH_REAR);
  assign is_front = (command_i == CMD_PUSH_FRONT) || (command_i == CMD_POP_FRONT);
  assign full     = (cnt_q == FullCnt);
  assign empty    = (cnt_q == '0);
  assign push_ok  = is_push && !full;
  assign pop_ok   = !is_push && !empty;
  assign word     = DataWidth'($unsigned(data_in_i));

  assign sts_o.pop_ok = pop_ok;

  // Work out the slot touched and the new pointers and count
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    slot     = is_front ? head_q : tail_q;
    status_d = ST_OK;
    if (is_push) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        if (empty) begin
          head_d = '0;
          tail_d = '0;
          slot   = '0;
        end else if (is_front) begin
          head_d = step_dn(head_q);
          slot   = head_d;
        end else begin
          tail_d = step_up(tail_q);
          slot   = tail_d;
        end
        cnt_d = cnt_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        if (cnt_q == CntW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else if (is_front) begin
          head_d = step_up(head_q);
        end else begin
          tail_d = step_dn(tail_q);
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      mem[slot] <= word;
    end
    if (cmd_i.exec && pop_ok) begin
      rd_q <= mem[slot];
    end
  end

  // Result registers: status and level at execute, word at execute or read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o   <= status_d;
      level_o    <= cnt_d;
      data_out_o <= '0;
    end else if (cmd_i.load_mem) begin
      data_out_o <= WordWidth'(rd_q);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/double_ended_queue.sv -----
// Double-ended queue over a circular store.
//
// Input channel (in_valid_i/in_ready_o) carries one command per item:
// push front, push rear, pop front or pop rear, with data_in_i for pushes.
// Output channel (out_valid_o/out_ready_i) returns one item per command:
// the popped word (zero otherwise), a status (ok, overflow, underflow) and
// the fill level after the command.
// A push or an error result is valid in the cycle after acceptance; a successful
// pop is first read into the read register and then loaded into the output word
// register, because the store has one read port with registered read data.
// Throughput: one push or error item per cycle as long as the receiver takes
// results; no new item is taken while a successful pop reads the store.
// The output register frees the input side: a new item is taken in the
// cycle the pending result is taken. When the receiver stalls, the result
// holds and no further item is accepted.
// Reset empties the queue (pointers and count to zero); store contents are
// left as they are and are never read before being written.
// Depends on deq_pkg, deq_ctrl and deq_dp.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned Depth     = deq_pkg::DefDepth,
  parameter int unsigned DataWidth = deq_pkg::DefDataWidth,
  localparam int unsigned LevelW   = $clog2(Depth + 1)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [deq_pkg::CmdWidth-1:0]         command_i,
  input  wire logic signed [deq_pkg::WordWidth-1:0] data_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [deq_pkg::WordWidth-1:0]      data_out_o,
  output logic [deq_pkg::StatusWidth-1:0]           status_o,
  output logic [LevelW-1:0]                         level_o
);
  import deq_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd)
  );

  deq_dp #(
    .Depth     (Depth),
    .DataWidth (DataWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctl_cmd),
    .sts_o      (dp_sts),
    .command_i  (command_i),
    .data_in_i  (data_in_i),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .level_o    (level_o)
  );

  // Level never exceeds the store depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o <= LevelW'(Depth)))
    else $error("level above depth");

  // Error results carry a zero word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (data_out_o == '0))
    else $error("error result with nonzero word");

  // A successful pop shows its result after the read cycle
  a_pop_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_cmd.exec && dp_sts.pop_ok) |=> (!out_valid_o && !in_ready_o) ##1 out_valid_o)
    else $error("pop result sequencing broken");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for double_ended_queue: random commands against a deque tracker.
// Valid/ready on both sides with random idling and two long receiver hold-offs.
// Depends on deq_pkg and the double_ended_queue RTL.
`default_nettype none

module testbench;
  import deq_pkg::*;

  localparam int unsigned DEPTH      = DefDepth;
  localparam int unsigned IdxW       = $clog2(DEPTH);
  localparam int unsigned LevelW     = $clog2(DEPTH + 1);
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandItems  = 850;
  localparam int unsigned HoldCycles = 60;

  typedef struct {
    logic [WordWidth-1:0]   word;
    logic [StatusWidth-1:0] status;
    logic [LevelW-1:0]      level;
  } deq_result_t;

  // Track deque contents and the result each command must give
  class deque_tracker;
    logic [WordWidth-1:0] slots [DEPTH];
    logic [IdxW-1:0]      head;
    logic [IdxW-1:0]      tail;
    bit                   empty;
    int unsigned          fill;
    deq_result_t          due[$];
    int unsigned          errors;
    int unsigned          accepted;

    function new();
      head     = '0;
      tail     = '0;
      empty    = 1'b1;
      fill     = 0;
      errors   = 0;
      accepted = 0;
    endfunction

    function logic [IdxW-1:0] idx_up(logic [IdxW-1:0] i);
      return (i == IdxW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function logic [IdxW-1:0] idx_down(logic [IdxW-1:0] i);
      return (i == '0) ? IdxW'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Apply one accepted command and queue its expected result
    function void note_command(logic [CmdWidth-1:0] cmd, logic [WordWidth-1:0] word);
      deq_result_t     r;
      logic [IdxW-1:0] slot;
      r.word   = '0;
      r.status = ST_OK;
      accepted++;
      if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
        if (fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (empty) begin
            head = '0;
            tail = '0;
            slot = '0;
          end else if (cmd == CMD_PUSH_FRONT) begin
            head = idx_down(head);
            slot = head;
          end else begin
            tail = idx_up(tail);
            slot = tail;
          end
          slots[slot] = word;
          empty = 1'b0;
          fill++;
        end
      end else begin
        if (empty) begin
          r.status = ST_UNDERFLOW;
        end else begin
          slot   = (cmd == CMD_POP_FRONT) ? head : tail;
          r.word = slots[slot];
          if (fill == 1) begin
            head  = '0;
            tail  = '0;
            empty = 1'b1;
          end else if (cmd == CMD_POP_FRONT) begin
            head = idx_up(head);
          end else begin
            tail = idx_down(tail);
          end
          fill--;
        end
      end
      r.level = LevelW'(fill);
      due.push_back(r);
    endfunction

    // Compare one taken result with the oldest expectation
    function void check_result(logic [WordWidth-1:0] word, logic [StatusWidth-1:0] status,
                               logic [LevelW-1:0] level);
      deq_result_t exp_r;
      if (due.size() == 0) begin
        $error("result with no command pending: data_out %h status %0d level %0d",
               word, status, level);
        errors++;
        return;
      end
      exp_r = due.pop_front();
      if (word !== exp_r.word) begin
        $error("data_out: expected %h, actual %h", exp_r.word, word);
        errors++;
      end
      if (status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, status);
        errors++;
      end
      if (level !== exp_r.level) begin
        $error("level: expected %0d, actual %0d", exp_r.level, level);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [CmdWidth-1:0]    command_i   = CMD_PUSH_FRONT;
  logic [WordWidth-1:0]   data_in_i   = '0;
  logic                   out_ready_i = 1'b0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [WordWidth-1:0]   data_out_o;
  logic [StatusWidth-1:0] status_o;
  logic [LevelW-1:0]      level_o;

  deque_tracker book = new();
  bit           steady = 1'b0;
  int unsigned  quiet_cycles = 0;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .level_o     (level_o)
  );

  always #1 clk_i = ~clk_i;

  // Offer one item, idling first at random, and hold it until taken
  task automatic offer(input logic [CmdWidth-1:0] cmd, input logic [WordWidth-1:0] word);
    if (!steady && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 35);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    data_in_i  <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book.note_command(cmd, word);
  endtask

  // Stimulus: directed corners, then random runs with varying push bias
  initial begin
    int unsigned          push_bias;
    logic [CmdWidth-1:0]  cmd;
    logic [WordWidth-1:0] word;
    bit                   is_push;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Underflow on both ends, then single-word round trips
    offer(CMD_POP_FRONT, 32'hFFFF_FFFF);
    offer(CMD_POP_REAR, 32'hFFFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    offer(CMD_POP_REAR, '0);
    offer(CMD_PUSH_REAR, 32'h8000_0000);
    offer(CMD_POP_FRONT, '0);
    // Fill from both ends until full, then overflow both ends
    offer(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    offer(CMD_PUSH_FRONT, 32'h0000_0000);
    offer(CMD_PUSH_REAR, 32'hAAAA_AAAA);
    offer(CMD_PUSH_REAR, 32'h5555_5555);
    offer(CMD_PUSH_FRONT, 32'h1234_5678);
    offer(CMD_PUSH_REAR, 32'hDEAD_BEEF);
    offer(CMD_PUSH_FRONT, 32'h0F0F_0F0F);
    offer(CMD_PUSH_REAR, 32'hF0F0_F0F0);
    offer(CMD_PUSH_FRONT, 32'h1111_1111);
    offer(CMD_PUSH_REAR, 32'h2222_2222);
    // Drain from alternating ends across the wrap point
    for (int k = 0; k < DEPTH; k++) begin
      offer((k % 2 == 0) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom());
    end
    offer(CMD_POP_FRONT, '0);

    push_bias = 50;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 20;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      steady  = (n >= 400 && n < 550);
      is_push = ($urandom_range(99) < push_bias);
      if (is_push) begin
        cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      end else begin
        cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
      end
      case ($urandom_range(9))
        0:       word = 32'hFFFF_FFFF;
        1:       word = 32'h0000_0000;
        2:       word = 32'h8000_0000;
        3:       word = 32'h7FFF_FFFF;
        default: word = $urandom();
      endcase
      offer(cmd, word);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow for stray ones
    while (book.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Receiver: check taken results, stall at random, hold off twice for a long stretch
  initial begin
    int unsigned hold_left;
    int unsigned holds;
    hold_left = 0;
    holds     = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        book.check_result(data_out_o, status_o, level_o);
      end
      if (hold_left == 0 && holds < 2 && book.accepted >= 250 * (holds + 1)) begin
        hold_left = HoldCycles;
        holds++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dp.sv
hdl/double_ended_queue.sv
tb/testbench.sv
